/* rtl/core/bmi_pkg.sv */
// Shared types and constants for the bilinear map interpolator.
// Used by bmi_div, bilinear_map_interpolator and the checker and testbench; no dependencies.
package bmi_pkg;

  localparam int unsigned GRID_POINTS = 16;
  localparam int unsigned IDX_W       = $clog2(GRID_POINTS);
  localparam int unsigned CELL_DEPTH  = GRID_POINTS * GRID_POINTS;
  localparam int unsigned CELL_AW     = $clog2(CELL_DEPTH);

  // Divider geometry: 16-bit quotient, 32-bit area, 48-bit biased numerator
  localparam int unsigned QUOT_W = 16;
  localparam int unsigned DEN_W  = 32;
  localparam int unsigned NUM_W  = DEN_W + QUOT_W;

  localparam logic [15:0] X_LOW_RESET  = 16'd300;
  localparam logic [15:0] X_HIGH_RESET = 16'd7000;
  localparam logic [15:0] Y_LOW_RESET  = 16'd20;
  localparam logic [15:0] Y_HIGH_RESET = 16'd200;

  typedef enum logic [1:0] {
    CMD_WRITE_X    = 2'd0,
    CMD_WRITE_Y    = 2'd1,
    CMD_WRITE_CELL = 2'd2,
    CMD_LOOKUP     = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_LIMITS      = 2'd1,
    ST_BREAKPOINTS = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    REG_X_LOW  = 2'd0,
    REG_X_HIGH = 2'd1,
    REG_Y_LOW  = 2'd2,
    REG_Y_HIGH = 2'd3
  } reg_e;

  // One stage of the pipelined restoring divider
  typedef struct packed {
    logic               valid;
    logic               use_value;
    status_e            status;
    logic [DEN_W-1:0]   den;
    logic [DEN_W-1:0]   rem;
    logic [QUOT_W-1:0]  low;
    logic [QUOT_W-1:0]  quot;
  } div_stage_t;

endpackage

/* rtl/core/bmi_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bmi_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/bmi_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on bmi_pkg (div_stage_t and divider widths).
module bmi_div import bmi_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  div_stage_t stage_i,
  output div_stage_t stage_o
);

  div_stage_t stage_q [QUOT_W+1];
  div_stage_t step_d  [QUOT_W];

  function automatic div_stage_t div_step(div_stage_t s);
    div_stage_t       r;
    logic [DEN_W:0]   cand;
    logic             take_bit;
    r        = s;
    cand     = {s.rem, s.low[QUOT_W-1]};
    take_bit = (cand >= {1'b0, s.den});
    if (take_bit) begin
      r.rem = DEN_W'(cand - {1'b0, s.den});
    end else begin
      r.rem = cand[DEN_W-1:0];
    end
    r.low  = {s.low[QUOT_W-2:0], 1'b0};
    r.quot = {s.quot[QUOT_W-2:0], take_bit};
    return r;
  endfunction

  // One trial subtract per stage
  always_comb begin
    for (int k = 0; k < QUOT_W; k++) begin
      step_d[k] = div_step(stage_q[k]);
    end
  end

  // Advance every stage each cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= QUOT_W; k++) begin
        stage_q[k] <= '0;
      end
    end else begin
      stage_q[0] <= stage_i;
      for (int k = 0; k < QUOT_W; k++) begin
        stage_q[k+1] <= step_d[k];
      end
    end
  end

  assign stage_o = stage_q[QUOT_W];

endmodule

/* rtl/core/bilinear_map_interpolator.sv */
// Bilinear map interpolator top level: breakpoint registers, cell RAMs,
// weight and product pipeline, biased floor divider. Uses bmi_pkg, bmi_ram, bmi_div.
//
// Every command (breakpoint write, cell write or lookup) yields exactly one
// result. The core is a fixed pipeline that takes a new command on every
// clock (busy stays low) and presents its result on done_o; results leave
// in command order. There is no back-pressure on results: the receiver
// cannot stall and must take each result in the one cycle that done_o is
// high. The divider has 16 quotient stages, behind the stages of search,
// cell read, multiply and sum. Cell writes land in the four corner RAM
// copies at the same stage where lookups read them, so each lookup sees
// exactly the writes issued before it. Limit registers are written over
// the cfg port, which is always ready; change them only while no lookup
// is in flight. Breakpoints and cells have no reset value.
module bilinear_map_interpolator import bmi_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         command_i,
  input  logic [3:0]         row_index_i,
  input  logic [3:0]         column_index_i,
  input  logic [15:0]        write_value_i,
  input  logic [15:0]        x_query_i,
  input  logic [15:0]        y_query_i,
  output logic signed [15:0] result_value_o,
  output logic [1:0]         status_o,
  output logic               done_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i
);

  logic accept;
  logic [15:0] x_low_q, x_high_q, y_low_q, y_high_q;
  logic [15:0] xbp_q [GRID_POINTS];
  logic [15:0] ybp_q [GRID_POINTS];

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;
  assign accept      = start && !busy;

  // Limit registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_low_q  <= X_LOW_RESET;
      x_high_q <= X_HIGH_RESET;
      y_low_q  <= Y_LOW_RESET;
      y_high_q <= Y_HIGH_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (reg_e'(cfg_index_i))
        REG_X_LOW:  x_low_q  <= cfg_data_i;
        REG_X_HIGH: x_high_q <= cfg_data_i;
        REG_Y_LOW:  y_low_q  <= cfg_data_i;
        REG_Y_HIGH: y_high_q <= cfg_data_i;
        default:    ;
      endcase
    end
  end

  // Breakpoint writes take effect at the accepting edge
  always_ff @(posedge clk_i) begin
    if (accept && cmd_e'(command_i) == CMD_WRITE_X
        && int'(column_index_i) < GRID_POINTS) begin
      xbp_q[IDX_W'(column_index_i)] <= write_value_i;
    end
    if (accept && cmd_e'(command_i) == CMD_WRITE_Y
        && int'(row_index_i) < GRID_POINTS) begin
      ybp_q[IDX_W'(row_index_i)] <= write_value_i;
    end
  end

  // ---------------- Stage 1: capture the transaction
  logic        s1_valid_q;
  cmd_e        s1_cmd_q;
  logic [3:0]  s1_row_q, s1_col_q;
  logic [15:0] s1_wval_q, s1_x_q, s1_y_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_cmd_q  <= cmd_e'(command_i);
    s1_row_q  <= row_index_i;
    s1_col_q  <= column_index_i;
    s1_wval_q <= write_value_i;
    s1_x_q    <= x_query_i;
    s1_y_q    <= y_query_i;
  end

  // ---------------- Stage 2: limits, bracket search, cell write decode
  logic [GRID_POINTS-1:0] x_above, y_above, x_first, y_first;
  logic [IDX_W-1:0]       xi_hi_d, xi_lo_d, yj_hi_d, yj_lo_d;
  logic [15:0]            x2_d, x1_d, y2_d, y1_d;
  logic                   limit_fail, bp_fail, cell_we_d;
  status_e                s2_status_d;

  always_comb begin
    for (int k = 0; k < GRID_POINTS; k++) begin
      x_above[k] = (xbp_q[k] > s1_x_q);
      y_above[k] = (ybp_q[k] > s1_y_q);
    end
    // Keep only the lowest-index breakpoint above the query
    x_first = x_above & (~x_above + GRID_POINTS'(1));
    y_first = y_above & (~y_above + GRID_POINTS'(1));
    xi_hi_d = '0; xi_lo_d = '0; yj_hi_d = '0; yj_lo_d = '0;
    x2_d = '0; x1_d = '0; y2_d = '0; y1_d = '0;
    for (int k = 0; k < GRID_POINTS; k++) begin
      xi_hi_d = xi_hi_d | ({IDX_W{x_first[k]}} & IDX_W'(k));
      yj_hi_d = yj_hi_d | ({IDX_W{y_first[k]}} & IDX_W'(k));
      x2_d    = x2_d | ({16{x_first[k]}} & xbp_q[k]);
      y2_d    = y2_d | ({16{y_first[k]}} & ybp_q[k]);
    end
    for (int k = 1; k < GRID_POINTS; k++) begin
      xi_lo_d = xi_lo_d | ({IDX_W{x_first[k]}} & IDX_W'(k - 1));
      yj_lo_d = yj_lo_d | ({IDX_W{y_first[k]}} & IDX_W'(k - 1));
      x1_d    = x1_d | ({16{x_first[k]}} & xbp_q[k-1]);
      y1_d    = y1_d | ({16{y_first[k]}} & ybp_q[k-1]);
    end
    limit_fail = (s1_x_q < x_low_q) || (s1_x_q > x_high_q)
              || (s1_y_q < y_low_q) || (s1_y_q > y_high_q);
    bp_fail    = !(|x_above) || x_above[0] || !(|y_above) || y_above[0];
    if (s1_cmd_q != CMD_LOOKUP) begin
      s2_status_d = ST_OK;
    end else if (limit_fail) begin
      s2_status_d = ST_LIMITS;
    end else if (bp_fail) begin
      s2_status_d = ST_BREAKPOINTS;
    end else begin
      s2_status_d = ST_OK;
    end
    cell_we_d = s1_valid_q && s1_cmd_q == CMD_WRITE_CELL
             && int'(s1_row_q) < GRID_POINTS && int'(s1_col_q) < GRID_POINTS;
  end

  logic                s2_valid_q, s2_use_q, s2_we_q;
  status_e             s2_status_q;
  logic [IDX_W-1:0]    s2_xi_hi_q, s2_xi_lo_q, s2_yj_hi_q, s2_yj_lo_q;
  logic [15:0]         s2_x1_q, s2_x2_q, s2_y1_q, s2_y2_q, s2_x_q, s2_y_q;
  logic [CELL_AW-1:0]  s2_waddr_q;
  logic [15:0]         s2_wdata_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s2_we_q    <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q;
      s2_we_q    <= cell_we_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s2_status_q <= s2_status_d;
    s2_use_q    <= (s1_cmd_q == CMD_LOOKUP) && (s2_status_d == ST_OK);
    s2_xi_hi_q  <= xi_hi_d;
    s2_xi_lo_q  <= xi_lo_d;
    s2_yj_hi_q  <= yj_hi_d;
    s2_yj_lo_q  <= yj_lo_d;
    s2_x1_q     <= x1_d;
    s2_x2_q     <= x2_d;
    s2_y1_q     <= y1_d;
    s2_y2_q     <= y2_d;
    s2_x_q      <= s1_x_q;
    s2_y_q      <= s1_y_q;
    s2_waddr_q  <= CELL_AW'(int'(s1_row_q) * GRID_POINTS + int'(s1_col_q));
    s2_wdata_q  <= s1_wval_q;
  end

  // ---------------- Stage 3: corner cell reads, weights and spans
  logic [CELL_AW-1:0] raddr [4];
  logic [15:0]        rdata [4];

  // Corners: low row low col, low row high col, high row low col, high row high col
  assign raddr[0] = CELL_AW'(int'(s2_yj_lo_q) * GRID_POINTS + int'(s2_xi_lo_q));
  assign raddr[1] = CELL_AW'(int'(s2_yj_lo_q) * GRID_POINTS + int'(s2_xi_hi_q));
  assign raddr[2] = CELL_AW'(int'(s2_yj_hi_q) * GRID_POINTS + int'(s2_xi_lo_q));
  assign raddr[3] = CELL_AW'(int'(s2_yj_hi_q) * GRID_POINTS + int'(s2_xi_hi_q));

  for (genvar c = 0; c < 4; c++) begin : g_cell_ram
    bmi_ram #(
      .WIDTH(16),
      .DEPTH(CELL_DEPTH)
    ) u_cells (
      .clk_i  (clk_i),
      .we_i   (s2_we_q),
      .waddr_i(s2_waddr_q),
      .wdata_i(s2_wdata_q),
      .raddr_i(raddr[c]),
      .rdata_o(rdata[c])
    );
  end

  logic        s3_valid_q, s3_use_q;
  status_e     s3_status_q;
  logic [15:0] s3_wx0_q, s3_wx1_q, s3_wy0_q, s3_wy1_q, s3_dx_q, s3_dy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_use_q    <= s2_use_q;
    s3_status_q <= s2_status_q;
    s3_wx0_q    <= s2_x2_q - s2_x_q;
    s3_wx1_q    <= s2_x_q - s2_x1_q;
    s3_wy0_q    <= s2_y2_q - s2_y_q;
    s3_wy1_q    <= s2_y_q - s2_y1_q;
    s3_dx_q     <= s2_x2_q - s2_x1_q;
    s3_dy_q     <= s2_y2_q - s2_y1_q;
  end

  // ---------------- Stage 4: area weights and cell area
  logic               s4_valid_q, s4_use_q;
  status_e            s4_status_q;
  logic [31:0]        s4_p_q [4];
  logic [DEN_W-1:0]   s4_den_q;
  logic signed [15:0] s4_c_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_use_q    <= s3_use_q;
    s4_status_q <= s3_status_q;
    s4_p_q[0]   <= 32'(s3_wx0_q) * 32'(s3_wy0_q);
    s4_p_q[1]   <= 32'(s3_wx1_q) * 32'(s3_wy0_q);
    s4_p_q[2]   <= 32'(s3_wx0_q) * 32'(s3_wy1_q);
    s4_p_q[3]   <= 32'(s3_wx1_q) * 32'(s3_wy1_q);
    s4_den_q    <= 32'(s3_dx_q) * 32'(s3_dy_q);
    for (int c = 0; c < 4; c++) begin
      s4_c_q[c] <= $signed(rdata[c]);
    end
  end

  // ---------------- Stage 5: weight each corner cell
  logic               s5_valid_q, s5_use_q;
  status_e            s5_status_q;
  logic signed [48:0] s5_t_q [4];
  logic [DEN_W-1:0]   s5_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_use_q    <= s4_use_q;
    s5_status_q <= s4_status_q;
    s5_den_q    <= s4_den_q;
    for (int c = 0; c < 4; c++) begin
      s5_t_q[c] <= $signed({1'b0, s4_p_q[c]}) * s4_c_q[c];
    end
  end

  // ---------------- Stage 6: pairwise sums
  logic               s6_valid_q, s6_use_q;
  status_e            s6_status_q;
  logic signed [49:0] s6_sa_q, s6_sb_q;
  logic [DEN_W-1:0]   s6_den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_valid_q <= 1'b0;
    end else begin
      s6_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s6_use_q    <= s5_use_q;
    s6_status_q <= s5_status_q;
    s6_den_q    <= s5_den_q;
    s6_sa_q     <= 50'(s5_t_q[0]) + 50'(s5_t_q[1]);
    s6_sb_q     <= 50'(s5_t_q[2]) + 50'(s5_t_q[3]);
  end

  // ---------------- Divider: bias the numerator by half range of area
  // Adding 2^15 * area makes the dividend non-negative and below
  // 2^16 * area, so an unsigned quotient with its top bit flipped is the floor.
  logic signed [50:0] num_biased;
  div_stage_t         div_in, div_out;

  assign num_biased = 51'(s6_sa_q) + 51'(s6_sb_q)
                    + $signed({4'b0, s6_den_q, 15'b0});

  always_comb begin
    div_in           = '0;
    div_in.valid     = s6_valid_q;
    div_in.use_value = s6_use_q;
    div_in.status    = s6_status_q;
    div_in.den       = s6_den_q;
    div_in.rem       = num_biased[NUM_W-1:QUOT_W];
    div_in.low       = num_biased[QUOT_W-1:0];
    div_in.quot      = '0;
  end

  bmi_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stage_i(div_in),
    .stage_o(div_out)
  );

  // ---------------- Output register
  logic               done_q;
  logic signed [15:0] value_q;
  status_e            status_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= div_out.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= div_out.status;
    if (div_out.use_value) begin
      value_q <= $signed({~div_out.quot[QUOT_W-1], div_out.quot[QUOT_W-2:0]});
    end else begin
      value_q <= '0;
    end
  end

  assign done_o         = done_q;
  assign result_value_o = value_q;
  assign status_o       = status_q;

endmodule

/* verif/bilinear_map_interpolator_checker.sv */
// Checker for the bilinear map interpolator: watches the command, result and limit channels,
// predicts each result from its own copy of the map and limits, and counts mismatches.
// Depends on bmi_pkg for command, status and register codes.
module bilinear_map_interpolator_checker
  import bmi_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  input  logic               busy,
  input  logic [1:0]         command_i,
  input  logic [3:0]         row_index_i,
  input  logic [3:0]         column_index_i,
  input  logic [15:0]        write_value_i,
  input  logic [15:0]        x_query_i,
  input  logic [15:0]        y_query_i,
  input  logic signed [15:0] result_value_i,
  input  logic [1:0]         status_i,
  input  logic               done_i,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [1:0]         cfg_index_i,
  input  logic [15:0]        cfg_data_i,
  output int                 fail_count_o,
  output int                 outstanding_o,
  output int                 lookups_ok_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [15:0] value;
    status_e            status;
  } map_result_t;

  logic [15:0] x_low, x_high, y_low, y_high;
  logic [15:0] x_bp [GRID_POINTS];
  logic [15:0] y_bp [GRID_POINTS];
  logic [15:0] cells [GRID_POINTS][GRID_POINTS];
  map_result_t expected_results [$];

  assign outstanding_o = expected_results.size();

  // Index of the first breakpoint strictly above the query, GRID_POINTS if none
  function automatic int first_above(input logic [15:0] grid [GRID_POINTS],
                                     input logic [15:0] q);
    int k;
    k = 0;
    while (k < GRID_POINTS && grid[k] <= q) k++;
    return k;
  endfunction

  // Blend the four corner cells and floor-divide by the cell area
  function automatic map_result_t interpolate(input logic [15:0] xq, input logic [15:0] yq);
    map_result_t r;
    int i, j;
    longint x1, x2, y1, y2, wx0, wx1, wy0, wy1, num, area, q;
    r.value  = '0;
    r.status = ST_OK;
    if (xq < x_low || xq > x_high || yq < y_low || yq > y_high) begin
      r.status = ST_LIMITS;
      return r;
    end
    i = first_above(x_bp, xq);
    j = first_above(y_bp, yq);
    if (i == 0 || j == 0 || i >= GRID_POINTS || j >= GRID_POINTS) begin
      r.status = ST_BREAKPOINTS;
      return r;
    end
    x1 = x_bp[i-1]; x2 = x_bp[i];
    y1 = y_bp[j-1]; y2 = y_bp[j];
    wx0 = x2 - xq; wx1 = xq - x1;
    wy0 = y2 - yq; wy1 = yq - y1;
    num = wx0 * wy0 * longint'($signed(cells[j-1][i-1]))
        + wx1 * wy0 * longint'($signed(cells[j-1][i]))
        + wx0 * wy1 * longint'($signed(cells[j][i-1]))
        + wx1 * wy1 * longint'($signed(cells[j][i]));
    area = (x2 - x1) * (y2 - y1);
    q = num / area;
    if (num % area != 0 && num < 0) q--;
    r.value = q[15:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    map_result_t exp_r, got;
    if (!rst_ni) begin
      x_low  <= X_LOW_RESET;
      x_high <= X_HIGH_RESET;
      y_low  <= Y_LOW_RESET;
      y_high <= Y_HIGH_RESET;
      expected_results.delete();
      fail_count_o = 0;
      lookups_ok_o = 0;
    end else begin
      // Compare a finished transaction against the oldest prediction
      if (done_i) begin
        if (expected_results.size() == 0) begin
          $display("%0t: result with nothing expected: value %0d status %0d",
                   $realtime, result_value_i, status_i);
          fail_count_o++;
        end else begin
          exp_r = expected_results.pop_front();
          if (result_value_i !== exp_r.value) begin
            $display("%0t: result_value expected %0d actual %0d",
                     $realtime, exp_r.value, result_value_i);
            fail_count_o++;
          end
          if (status_i !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d",
                     $realtime, exp_r.status, status_i);
            fail_count_o++;
          end
        end
      end
      // Track limit register writes
      if (cfg_valid_i && cfg_ready_i) begin
        case (reg_e'(cfg_index_i))
          REG_X_LOW:  x_low  <= cfg_data_i;
          REG_X_HIGH: x_high <= cfg_data_i;
          REG_Y_LOW:  y_low  <= cfg_data_i;
          REG_Y_HIGH: y_high <= cfg_data_i;
          default: ;
        endcase
      end
      // Predict an accepted command; writes update the map in place
      if (start && !busy) begin
        got.value  = '0;
        got.status = ST_OK;
        case (cmd_e'(command_i))
          CMD_WRITE_X:    x_bp[column_index_i] = write_value_i;
          CMD_WRITE_Y:    y_bp[row_index_i] = write_value_i;
          CMD_WRITE_CELL: cells[row_index_i][column_index_i] = write_value_i;
          default: begin
            got = interpolate(x_query_i, y_query_i);
            if (got.status == ST_OK) lookups_ok_o++;
          end
        endcase
        expected_results.push_back(got);
      end
    end
  end

endmodule

/* verif/bilinear_map_interpolator_tb.sv */
// Testbench top for the bilinear map interpolator: clock, reset, command and limit stimulus.
// Depends on bmi_pkg, the RTL and bilinear_map_interpolator_checker.
module bilinear_map_interpolator_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bmi_pkg::*;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         command_i = CMD_LOOKUP;
  logic [3:0]         row_index_i = '0;
  logic [3:0]         column_index_i = '0;
  logic [15:0]        write_value_i = '0;
  logic [15:0]        x_query_i = '0;
  logic [15:0]        y_query_i = '0;
  logic signed [15:0] result_value_o;
  logic [1:0]         status_o;
  logic               done_o;
  logic               cfg_valid_i = 1'b0;
  logic               cfg_ready_o;
  logic [1:0]         cfg_index_i = REG_X_LOW;
  logic [15:0]        cfg_data_i = '0;

  int fail_count, outstanding, lookups_ok;
  int commands_sent, settings_used;
  bit no_gaps;
  logic [15:0] x_grid [GRID_POINTS];
  logic [15:0] y_grid [GRID_POINTS];

  always #2 clk_i = ~clk_i;

  bilinear_map_interpolator uut (.*);

  bilinear_map_interpolator_checker checker_i (
    .clk_i, .rst_ni, .start, .busy, .command_i, .row_index_i, .column_index_i,
    .write_value_i, .x_query_i, .y_query_i,
    .result_value_i(result_value_o), .status_i(status_o), .done_i(done_o),
    .cfg_valid_i, .cfg_ready_i(cfg_ready_o), .cfg_index_i, .cfg_data_i,
    .fail_count_o(fail_count), .outstanding_o(outstanding), .lookups_ok_o(lookups_ok)
  );

  // Hold one transaction until accepted, then idle for a random gap, which may be zero
  task automatic send(input cmd_e cmd, input int row, input int col,
                      input int wval, input int xq, input int yq);
    bit ok;
    int gap, pick;
    start          <= 1'b1;
    command_i      <= cmd;
    row_index_i    <= 4'(row);
    column_index_i <= 4'(col);
    write_value_i  <= 16'(wval);
    x_query_i      <= 16'(xq);
    y_query_i      <= 16'(yq);
    if (cmd == CMD_WRITE_X) x_grid[4'(col)] = 16'(wval);
    if (cmd == CMD_WRITE_Y) y_grid[4'(row)] = 16'(wval);
    forever begin
      ok = !busy;
      @(negedge clk_i);
      if (ok) break;
    end
    commands_sent++;
    pick = $urandom_range(99);
    gap = (no_gaps || pick < 60) ? 0 : (pick < 90) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  task automatic write_limit(input reg_e idx, input int value);
    bit ok;
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= 16'(value);
    forever begin
      ok = cfg_ready_o;
      @(negedge clk_i);
      if (ok) break;
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Stop issuing, drain every result, then let the pipeline empty out
  task automatic settle();
    start <= 1'b0;
    while (outstanding != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  // Load rising breakpoints on both axes with random spacing inside each step
  task automatic load_axes(input int x_base, input int x_step, input int y_base,
                           input int y_step);
    for (int k = 0; k < GRID_POINTS; k++) begin
      send(CMD_WRITE_X, $urandom, k, x_base + k * x_step + $urandom_range(x_step - 1), 0, 0);
      send(CMD_WRITE_Y, k, $urandom, y_base + k * y_step + $urandom_range(y_step - 1), 0, 0);
    end
  endtask

  // Mostly lookups aimed inside the grid, plus map rewrites and full-range noise
  task automatic random_items(input int count);
    int pick, k, v;
    int xq, yq;
    for (int n = 0; n < count; n++) begin
      pick = $urandom_range(99);
      if (pick < 60) begin
        k = $urandom_range(GRID_POINTS - 1);
        if (pick < 40) begin
          xq = $urandom_range(x_grid[0] > 20 ? x_grid[0] - 20 : 0,
                              x_grid[15] < 65515 ? x_grid[15] + 20 : 65535);
          yq = $urandom_range(y_grid[0] > 5 ? y_grid[0] - 5 : 0,
                              y_grid[15] < 65530 ? y_grid[15] + 5 : 65535);
        end else if (pick < 48) begin
          xq = x_grid[k];
          yq = y_grid[$urandom_range(GRID_POINTS - 1)];
        end else begin
          xq = $urandom_range(65535);
          yq = $urandom_range(65535);
        end
        send(CMD_LOOKUP, $urandom, $urandom, $urandom, xq, yq);
      end else if (pick < 80) begin
        send(CMD_WRITE_CELL, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        k = $urandom_range(GRID_POINTS - 1);
        if (pick < 90) begin
          v = (pick < 86) ? int'(x_grid[k]) + $urandom_range(100) - 50 : $urandom_range(65535);
          v = v < 0 ? 0 : v > 65535 ? 65535 : v;
          send(CMD_WRITE_X, $urandom, k, v, $urandom, $urandom);
        end else begin
          v = (pick < 96) ? int'(y_grid[k]) + $urandom_range(10) - 5 : $urandom_range(65535);
          v = v < 0 ? 0 : v > 65535 ? 65535 : v;
          send(CMD_WRITE_Y, k, $urandom, v, $urandom, $urandom);
        end
      end
    end
  endtask

  initial begin
    #2ms;
    $display("timeout: %0d results still expected", outstanding);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    commands_sent = 0;
    settings_used = 1;
    no_gaps = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Fill every breakpoint and cell so no lookup reads an unwritten entry
    load_axes(400, 400, 30, 10);
    for (int r = 0; r < GRID_POINTS; r++)
      for (int c = 0; c < GRID_POINTS; c++)
        send(CMD_WRITE_CELL, r, c, $urandom, $urandom, $urandom);

    // Directed: limit edges, grid edges, breakpoint hits and cell extremes
    send(CMD_LOOKUP, 0, 0, 0, X_LOW_RESET, Y_LOW_RESET);
    send(CMD_LOOKUP, 0, 0, 0, X_HIGH_RESET, Y_HIGH_RESET);
    send(CMD_LOOKUP, 0, 0, 0, X_LOW_RESET - 1, 100);
    send(CMD_LOOKUP, 0, 0, 0, X_HIGH_RESET + 1, 100);
    send(CMD_LOOKUP, 0, 0, 0, 3000, Y_LOW_RESET - 1);
    send(CMD_LOOKUP, 0, 0, 0, 3000, Y_HIGH_RESET + 1);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[0] - 1, y_grid[4]);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[15], y_grid[4]);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[3], y_grid[0] - 1);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[3], y_grid[15]);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[15] - 1, y_grid[15] - 1);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[5], y_grid[7]);
    for (int r = 2; r < 4; r++)
      for (int c = 2; c < 4; c++) send(CMD_WRITE_CELL, r, c, 16'h8000, 0, 0);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[2] + 1, y_grid[2] + 1);
    for (int r = 2; r < 4; r++)
      for (int c = 2; c < 4; c++) send(CMD_WRITE_CELL, r, c, 16'h7fff, 0, 0);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[2] + 1, y_grid[2] + 1);
    send(CMD_WRITE_CELL, 2, 2, 16'h8000, 0, 0);
    send(CMD_LOOKUP, 0, 0, 0, x_grid[2] + 3, y_grid[2] + 2);

    random_items(60);

    // Widest limits with breakpoints spread over the whole range
    settle();
    settings_used++;
    write_limit(REG_X_LOW, 16'h0000);
    write_limit(REG_X_HIGH, 16'hffff);
    write_limit(REG_Y_LOW, 16'h0000);
    write_limit(REG_Y_HIGH, 16'hffff);
    no_gaps = 1'b1;
    load_axes(0, 4096, 0, 4096);
    send(CMD_LOOKUP, 0, 0, 0, 16'hffff, 16'hffff);
    send(CMD_LOOKUP, 0, 0, 0, 16'h0000, 16'h0000);
    random_items(80);

    // Random limits inside a normal map
    settle();
    settings_used++;
    no_gaps = 1'b0;
    load_axes(400, 400, 30, 10);
    settle();
    write_limit(REG_X_LOW, $urandom_range(300, 3000));
    write_limit(REG_X_HIGH, $urandom_range(3000, 7000));
    write_limit(REG_Y_LOW, $urandom_range(20, 90));
    write_limit(REG_Y_HIGH, $urandom_range(90, 200));
    random_items(70);

    // Low above high on both axes rejects every lookup
    settle();
    settings_used++;
    write_limit(REG_X_LOW, 16'hffff);
    write_limit(REG_X_HIGH, 16'h0000);
    write_limit(REG_Y_LOW, 16'd200);
    write_limit(REG_Y_HIGH, 16'd20);
    random_items(30);

    // Back to the reset limits
    settle();
    settings_used++;
    write_limit(REG_X_LOW, X_LOW_RESET);
    write_limit(REG_X_HIGH, X_HIGH_RESET);
    write_limit(REG_Y_LOW, Y_LOW_RESET);
    write_limit(REG_Y_HIGH, Y_HIGH_RESET);
    no_gaps = 1'b1;
    load_axes(400, 400, 30, 10);
    no_gaps = 1'b0;
    random_items(50);

    start <= 1'b0;
    settle();
    $display("ran %0d commands over %0d limit settings, %0d lookups interpolated",
             commands_sent, settings_used, lookups_ok);
    if (fail_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
